>>> hw/rtl/rffa_pkg.sv
// Package: shared types, constants and helpers for the feed failover arbiter.
`timescale 1ns / 1ps
package rffa_pkg;
    localparam int NUM_FEEDS = 4;
    localparam int FIDX_W = 2;
    localparam int CNT_W = 32;
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [0:0] {
        OP_OBSERVE  = 1'b0,
        OP_EVALUATE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        TRUST_UNSEEN = 2'd0,
        TRUST_FRESH  = 2'd1,
        TRUST_STALE  = 2'd2
    } trust_t;

    typedef enum logic [1:0] {
        CFG_STALE_THRESHOLD = 2'd0,
        CFG_RECOVERY_HOLD   = 2'd1,
        CFG_PRIMARY_INDEX   = 2'd2,
        CFG_FEEDS_IN_USE    = 2'd3
    } cfg_idx_t;

    // item queued between front and back
    typedef struct packed {
        logic        op;
        logic [1:0]  feed_id;
        logic [63:0] sequence_req;
        logic [47:0] now;
    } item_t;

    localparam int ITEM_W = $bits(item_t);
    localparam int OUT_W = 9 + 5 * CNT_W;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + CNT_W'(1);
    endfunction
endpackage

>>> hw/rtl/redundant_feed_failover_arbiter.sv
// Top level: feed failover arbiter with intake queue and engine.
`timescale 1ns / 1ps
// Usage:
//  s_axis: one word per item; tuser is the operation (0 observe, 1 evaluate),
//  tdata packs feed_id, sequence_req and now. m_axis returns one word per
//  item with flags in tuser and active feed plus counters in tdata.
//  cfg: index/data write channel, always ready; write only while idle.
//  Processing: an observe item or a bad feed goes from the queue head through
//  check to done; evaluate goes through check, a scan that visits each feed in
//  use in turn, select and done. The engine takes the next item only when back
//  in idle, after its result is registered; the two-word queue lets the intake
//  keep taking words while the engine works.
//  Reset: asynchronous, clears all feed state, counters and config to
//  defaults; a held result stays in the output register while m_axis_tready
//  is low and the engine then waits with the next result.
module redundant_feed_failover_arbiter
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [119:0]  s_axis_tdata,  // feed_id, sequence_req, now, pad
    input  logic          s_axis_tuser,  // operation
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [167:0]  m_axis_tdata,  // active_valid, active_index, switch,
                                         // untrusted, pstale, recovery, regress
    output logic [5:0]    m_axis_tuser,  // accepted, regressed, bad_feed,
                                         // forward, trust_state
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [1:0]    cfg_index,
    input  logic [31:0]   cfg_data
);
    rffa_pkg::item_t in_item;
    rffa_pkg::item_t q_item;
    logic q_valid;
    logic q_ready;
    logic [rffa_pkg::OUT_W-1:0] res;

    assign in_item.op           = s_axis_tuser;
    assign in_item.feed_id      = s_axis_tdata[1:0];
    assign in_item.sequence_req = s_axis_tdata[65:2];
    assign in_item.now          = s_axis_tdata[113:66];
    assign cfg_ready = 1'b1;

    rffa_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
        .out_valid(q_valid), .out_ready(q_ready), .out_item(q_item)
    );

    rffa_engine u_engine
    (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .item_valid(q_valid), .item_ready(q_ready), .item(q_item),
        .res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res_data(res)
    );

    assign m_axis_tuser = res[5:0];
    assign m_axis_tdata = {5'd0, res[168:6]};

    a_no_both: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
        else $error("accepted and regressed together");
    a_idx_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[2:1] == 2'd0))
        else $error("active index set without active feed");
    a_queue_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (!s_axis_tready) |-> q_valid)
        else $error("queue full while empty");
endmodule

>>> hw/rtl/rffa_queue.sv
// Module: two-entry item queue between the intake and the arbiter engine.
`timescale 1ns / 1ps
module rffa_queue
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  rffa_pkg::item_t       in_item,
    output logic                  out_valid,
    input  logic                  out_ready,
    output rffa_pkg::item_t       out_item
);
    rffa_pkg::item_t mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign push = in_valid && in_ready;
    assign pop  = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= in_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end
endmodule

>>> hw/rtl/rffa_engine.sv
// Module: arbiter engine; applies observe items and walks feeds for evaluate.
`timescale 1ns / 1ps
module rffa_engine
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    input  logic [1:0]                         cfg_index,
    input  logic [31:0]                        cfg_data,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  rffa_pkg::item_t                    item,
    output logic                               res_valid,
    input  logic                               res_ready,
    output logic [rffa_pkg::OUT_W-1:0]         res_data
);
    localparam int NF = rffa_pkg::NUM_FEEDS;
    localparam int OUT_W_L = rffa_pkg::OUT_W;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_CHECK  = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_SELECT = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [31:0] stale_thr_reg;
    logic [31:0] hold_reg;
    logic [1:0]  prim_reg;
    logic [2:0]  fin_reg;

    logic        seen_reg  [NF];
    logic [63:0] seq_reg   [NF];
    logic [47:0] time_reg  [NF];
    logic [1:0]  trust_reg [NF];
    logic        cur_valid_reg;
    logic [1:0]  cur_index_reg;
    logic        trust_est_reg;
    logic        p_stale_reg;
    logic        rec_valid_reg;
    logic [47:0] rec_time_reg;
    logic [31:0] cnt_reg [5];

    rffa_pkg::item_t it_reg;
    logic [1:0]  scan_reg;
    logic        fresh_reg [NF];
    logic [2:0]  flag_reg;
    logic [OUT_W_L-1:0] out_reg;
    logic        out_valid_reg;

    // live feed count, clamped to 1..NF
    logic [2:0] live;
    always_comb
    begin
        if (fin_reg == 3'd0)
            live = 3'd1;
        else if (fin_reg > 3'(NF))
            live = 3'(NF);
        else
            live = fin_reg;
    end

    // age check against the scanned feed during scan, else the item's feed (used for observe and scan)
    logic [1:0]  sel_idx;
    logic [48:0] age;
    logic        age_neg;
    logic        age_fresh;
    assign sel_idx = (state_reg == ST_SCAN) ? scan_reg : it_reg.feed_id;
    assign age     = {1'b0, it_reg.now} - {1'b0, time_reg[sel_idx]};
    assign age_neg = age[48];
    assign age_fresh = !age_neg && (age[47:0] <= {16'd0, stale_thr_reg});

    logic [48:0] rec_age;
    logic        hold_ok;
    assign rec_age = {1'b0, it_reg.now} - {1'b0, rec_time_reg};
    assign hold_ok = !rec_age[48] && (rec_age[47:0] >= {16'd0, hold_reg});

    logic prim_in;
    logic prim_fresh;
    logic prim_ok;
    logic cur_fresh;
    logic bk_found;
    logic [1:0] bk_idx;
    assign prim_in    = {1'b0, prim_reg} < live;
    assign prim_fresh = prim_in && fresh_reg[prim_reg];
    assign prim_ok    = prim_fresh && (!p_stale_reg || (rec_valid_reg && hold_ok));
    assign cur_fresh  = cur_valid_reg && ({1'b0, cur_index_reg} < live)
                        && fresh_reg[cur_index_reg];
    always_comb
    begin
        bk_found = 1'b0;
        bk_idx = 2'd0;
        for (int i = NF - 1; i >= 0; i--)
        begin
            if (3'(i) < live && 2'(i) != prim_reg && fresh_reg[i])
            begin
                bk_found = 1'b1;
                bk_idx = 2'(i);
            end
        end
    end

    logic       bad;
    logic       is_obs;
    logic       seq_back;
    assign bad      = {1'b0, it_reg.feed_id} >= live;
    assign is_obs   = (it_reg.op == rffa_pkg::OP_OBSERVE);
    assign seq_back = seen_reg[it_reg.feed_id] &&
                      (it_reg.sequence_req <= seq_reg[it_reg.feed_id]);

    assign item_ready = (state_reg == ST_IDLE);
    assign res_valid  = out_valid_reg;
    assign res_data   = out_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (item_valid) state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (bad || is_obs)
                    state_next = ST_DONE;
                else
                    state_next = ST_SCAN;
            end
            ST_SCAN:   if ({1'b0, scan_reg} == live - 3'd1) state_next = ST_SELECT;
            ST_SELECT: state_next = ST_DONE;
            ST_DONE:   if (!out_valid_reg || res_ready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && item_valid)
            it_reg <= item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            stale_thr_reg <= 32'd100;
            hold_reg      <= 32'd0;
            prim_reg      <= 2'd0;
            fin_reg       <= 3'd4;
            cur_valid_reg <= 1'b0;
            cur_index_reg <= 2'd0;
            trust_est_reg <= 1'b0;
            p_stale_reg   <= 1'b0;
            rec_valid_reg <= 1'b0;
            rec_time_reg  <= 48'd0;
            scan_reg      <= 2'd0;
            flag_reg      <= 3'd0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            for (int i = 0; i < NF; i++)
            begin
                seen_reg[i]  <= 1'b0;
                trust_reg[i] <= rffa_pkg::TRUST_UNSEEN;
                fresh_reg[i] <= 1'b0;
                seq_reg[i]   <= 64'd0;
                time_reg[i]  <= 48'd0;
            end
            for (int k = 0; k < 5; k++)
                cnt_reg[k] <= 32'd0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid)
            begin
                case (cfg_index)
                    rffa_pkg::CFG_STALE_THRESHOLD: stale_thr_reg <= cfg_data;
                    rffa_pkg::CFG_RECOVERY_HOLD:   hold_reg <= cfg_data;
                    rffa_pkg::CFG_PRIMARY_INDEX:   prim_reg <= cfg_data[1:0];
                    rffa_pkg::CFG_FEEDS_IN_USE:    fin_reg <= cfg_data[2:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_DONE && (!out_valid_reg || res_ready))
                out_valid_reg <= 1'b1;
            else if (res_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_CHECK:
                begin
                    scan_reg <= 2'd0;
                    for (int i = 0; i < NF; i++)
                        fresh_reg[i] <= 1'b0;
                    // flags held here; out_reg may still carry the previous word
                    flag_reg[0] <= !bad && is_obs && !seq_back;
                    flag_reg[1] <= !bad && is_obs && seq_back;
                    flag_reg[2] <= bad;
                    if (!bad && is_obs)
                    begin
                        if (seq_back)
                        begin
                            cnt_reg[4] <= rffa_pkg::sat_inc(cnt_reg[4]);
                        end
                        else
                        begin
                            seen_reg[it_reg.feed_id]  <= 1'b1;
                            seq_reg[it_reg.feed_id]   <= it_reg.sequence_req;
                            time_reg[it_reg.feed_id]  <= it_reg.now;
                            trust_reg[it_reg.feed_id] <= rffa_pkg::TRUST_FRESH;
                            if (it_reg.feed_id == prim_reg && p_stale_reg &&
                                seen_reg[it_reg.feed_id] && !age_fresh)
                            begin
                                rec_valid_reg <= 1'b1;
                                rec_time_reg  <= it_reg.now;
                                cnt_reg[3] <= rffa_pkg::sat_inc(cnt_reg[3]);
                            end
                        end
                    end
                end
                ST_SCAN:
                begin
                    scan_reg <= scan_reg + 2'd1;
                    if (!seen_reg[scan_reg])
                        trust_reg[scan_reg] <= rffa_pkg::TRUST_UNSEEN;
                    else if (age_fresh)
                    begin
                        trust_reg[scan_reg] <= rffa_pkg::TRUST_FRESH;
                        fresh_reg[scan_reg] <= 1'b1;
                    end
                    else if (trust_reg[scan_reg] != rffa_pkg::TRUST_STALE)
                    begin
                        trust_reg[scan_reg] <= rffa_pkg::TRUST_STALE;
                        if (scan_reg == prim_reg)
                        begin
                            cnt_reg[2] <= rffa_pkg::sat_inc(cnt_reg[2]);
                            p_stale_reg <= 1'b1;
                            rec_valid_reg <= 1'b0;
                        end
                    end
                end
                ST_SELECT:
                begin
                    if (!(cur_fresh && (cur_index_reg == prim_reg || !prim_ok)))
                    begin
                        if (prim_ok || bk_found)
                        begin
                            if (!cur_valid_reg ||
                                cur_index_reg != (prim_ok ? prim_reg : bk_idx))
                            begin
                                if (cur_valid_reg)
                                    cnt_reg[0] <= rffa_pkg::sat_inc(cnt_reg[0]);
                                cur_valid_reg <= 1'b1;
                                cur_index_reg <= prim_ok ? prim_reg : bk_idx;
                                trust_est_reg <= 1'b1;
                            end
                        end
                        else if (cur_valid_reg)
                        begin
                            if (trust_est_reg)
                                cnt_reg[1] <= rffa_pkg::sat_inc(cnt_reg[1]);
                            cur_valid_reg <= 1'b0;
                            cur_index_reg <= 2'd0;
                        end
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || res_ready)
                    begin
                        out_reg[2:0] <= flag_reg;
                        if (!bad && it_reg.op == rffa_pkg::OP_EVALUATE)
                        begin
                            out_reg[3] <= cur_valid_reg &&
                                          cur_index_reg == it_reg.feed_id;
                            out_reg[5:4] <= trust_reg[it_reg.feed_id];
                        end
                        else
                        begin
                            out_reg[3] <= 1'b0;
                            out_reg[5:4] <= rffa_pkg::TRUST_UNSEEN;
                        end
                        out_reg[6] <= cur_valid_reg;
                        out_reg[7] <= cur_valid_reg ? cur_index_reg[0] : 1'b0;
                        out_reg[8] <= cur_valid_reg ? cur_index_reg[1] : 1'b0;
                        out_reg[40:9]    <= cnt_reg[0];
                        out_reg[72:41]   <= cnt_reg[1];
                        out_reg[104:73]  <= cnt_reg[2];
                        out_reg[136:105] <= cnt_reg[3];
                        out_reg[168:137] <= cnt_reg[4];
                    end
                end
                default: ;
            endcase
        end
    end
endmodule
